### hdl/sorted_integer_set_operations_top_macros.svh
// Assertion macros for the sorted set block.
`ifndef SORTED_INTEGER_SET_OPERATIONS_TOP_MACROS_SVH
`define SORTED_INTEGER_SET_OPERATIONS_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SSO_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SSO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/sso_pkg.sv
// ----------------------------------------------------------------------------
// sso_pkg
// Types and codes shared by the sorted set operation block.
// ----------------------------------------------------------------------------
package sso_pkg;

   localparam logic [1:0] MODE_FIRST  = 2'd0;
   localparam logic [1:0] MODE_SECOND = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   localparam logic [1:0] OP_UNION = 2'd0;
   localparam logic [1:0] OP_INTER = 2'd1;
   localparam logic [1:0] OP_SYMD  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_res;
      logic               last;
      logic               empty_res;
      logic               overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,     // search insert position
      ST_SHIFT,    // move entries up one slot
      ST_MRD,      // merge: issue reads
      ST_MCMP,     // merge: compare heads
      ST_EMIT,     // hold one result until taken
      ST_MEND      // final result: held element or empty marker
   } state_type;

   // Control from sequencer to the set store.
   typedef struct packed {
      logic       sel_b;
      logic       wr;
      logic [4:0] wr_addr;
      logic       wr_from_rd;
   } store_ctl_type;

   function automatic logic key_lt(logic [31:0] a, logic [31:0] b);
      return (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
   endfunction

endpackage

### hdl/sorted_integer_set_operations_top.sv
// ----------------------------------------------------------------------------
// sorted_integer_set_operations_top
// Two sorted signed sets; finish emits union, intersection or sym. difference.
// ----------------------------------------------------------------------------
// channel | ports              | direction | payload
// request | req_valid/req_ready| in        | req_type {mode, value}
// result  | rsp_valid/rsp_ready| out       | rsp_type {value_res, last, ...}
// csr     | csr_we/csr_wdata   | in        | operation, 2 bits
//
// Insert: one read of the set per cycle while searching, one move per cycle
// while shifting. Finish: the merge comparator reads a head pair in ST_MRD
// and compares it in ST_MCMP; each kept element is held until the next is
// found so the final one carries last; results go out through ST_EMIT while
// the sink is ready, the final one is built in ST_MEND first.
// reset is synchronous; sets are not cleared, the counts are.
// req_ready is low while a request is in work or a result is pending.
`include "sorted_integer_set_operations_top_macros.svh"
module sorted_integer_set_operations_top import sso_pkg::*; #(
   parameter int SET_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_wdata
);
   localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int CW = $clog2(SET_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

   state_type state_ff, state_in;
   logic [1:0]    op_ff;
   logic [CW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic          drop_ff, drop_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;   // scan / merge indices
   logic          sel_b_ff, sel_b_in;
   logic [31:0]   val_ff, val_in;
   logic          any_ff, any_in;            // a kept element is held in val_ff
   rsp_type       out_ff, out_in;
   logic [CW-1:0] cnt;                       // count of the set being inserted

   store_ctl_type ctl;
   logic [31:0]   rd_a, rd_b;
   logic [AW-1:0] ra, rb;

   sso_store #(.AW(AW)) u_store (
      .clock, .ctl, .wr_data(val_ff), .rd_addr_a(ra), .rd_addr_b(rb),
      .rd_a, .rd_b
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_UNION;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) op_ff <= csr_wdata;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         drop_ff  <= drop_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      sel_b_ff <= sel_b_in;
      val_ff   <= val_in;
      any_ff   <= any_in;
      out_ff   <= out_in;
   end

   assign cnt = sel_b_ff ? cnt_b_ff : cnt_a_ff;

   logic [31:0] rd_sel;
   logic [31:0] elem;                        // head chosen by the merge step
   logic        a_left, b_left, take, eq, a_lt;
   assign rd_sel = sel_b_ff ? rd_b : rd_a;
   assign a_left = i_ff < cnt_a_ff;
   assign b_left = j_ff < cnt_b_ff;
   assign eq     = rd_a == rd_b;
   assign a_lt   = key_lt(rd_a, rd_b);

   always_comb begin
      state_in = state_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      drop_in  = drop_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      sel_b_in = sel_b_ff;
      val_in   = val_ff;
      any_in   = any_ff;
      out_in   = out_ff;
      ctl      = '0;
      ctl.sel_b = sel_b_ff;
      ra = i_ff[AW-1:0];
      rb = j_ff[AW-1:0];
      take = 1'b0;
      elem = rd_a;
      req_ready = state_ff == ST_IDLE;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in = req_data.value;
               i_in = '0;
               j_in = '0;
               any_in = 1'b0;
               unique case (req_data.mode)
                  MODE_FIRST:  begin sel_b_in = 1'b0; state_in = ST_SCAN; end
                  MODE_SECOND: begin sel_b_in = 1'b1; state_in = ST_SCAN; end
                  MODE_FINISH: state_in = ST_MRD;
                  default: ;
               endcase
               ra = '0;
               rb = '0;
            end
         end
         ST_SCAN: begin
            // rd_sel holds entry i (read issued last cycle)
            if (i_ff < cnt && key_lt(rd_sel, val_ff)) begin
               i_in = i_ff + 1'b1;
               ra = AW'(i_ff + 1'b1);
               rb = AW'(i_ff + 1'b1);
            end else if (i_ff < cnt && rd_sel == val_ff) begin
               state_in = ST_IDLE;
            end else if (cnt >= DEPTH_C) begin
               drop_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               j_in = cnt;          // move pointer: slot being filled
               ra = AW'(cnt - 1'b1);
               rb = AW'(cnt - 1'b1);
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            ctl.wr = 1'b1;
            ctl.wr_addr = 5'(j_ff);
            if (j_ff == i_ff) begin
               ctl.wr_from_rd = 1'b0;
               if (sel_b_ff) cnt_b_in = cnt_b_ff + 1'b1;
               else          cnt_a_in = cnt_a_ff + 1'b1;
               state_in = ST_IDLE;
            end else begin
               ctl.wr_from_rd = 1'b1;
               j_in = j_ff - 1'b1;
               ra = AW'(j_ff - 2'd2);
               rb = AW'(j_ff - 2'd2);
            end
         end
         ST_MRD: begin
            state_in = ST_MCMP;
            if (op_ff == OP_NONE || (!a_left && !b_left)) state_in = ST_MEND;
         end
         ST_MCMP: begin
            if (a_left && b_left && eq) begin
               elem = rd_a; i_in = i_ff + 1'b1; j_in = j_ff + 1'b1;
               take = op_ff != OP_SYMD;
            end else if (!b_left || (a_left && a_lt)) begin
               elem = rd_a; i_in = i_ff + 1'b1;
               take = op_ff != OP_INTER;
            end else begin
               elem = rd_b; j_in = j_ff + 1'b1;
               take = op_ff != OP_INTER;
            end
            ra = i_in[AW-1:0];
            rb = j_in[AW-1:0];
            if (take) begin
               val_in = elem;
               any_in = 1'b1;
            end
            if (take && any_ff) begin
               // a newer element exists, so the held one is not the last
               out_in.value_res = val_ff;
               out_in.empty_res = 1'b0;
               out_in.overflow  = drop_ff;
               out_in.last      = 1'b0;
               state_in = ST_EMIT;
            end else if (!(i_in < cnt_a_ff) && !(j_in < cnt_b_ff)) begin
               state_in = ST_MEND;
            end else begin
               state_in = ST_MRD;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (out_ff.last) begin
                  cnt_a_in = '0; cnt_b_in = '0; drop_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MRD;
               end
            end
         end
         ST_MEND: begin
            // held element goes out marked last; none held means empty result
            out_in.value_res = any_ff ? val_ff : '0;
            out_in.empty_res = !any_ff;
            out_in.last      = 1'b1;
            out_in.overflow  = drop_ff;
            state_in = ST_EMIT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_data = out_ff;

   `SSO_ASSERT_IMP(a_no_ready_busy, clock, reset, state_ff != ST_IDLE, !req_ready,
      "ready while busy")
   `SSO_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1,
      cnt_a_ff <= DEPTH_C && cnt_b_ff <= DEPTH_C, "count above depth")
   `SSO_ASSERT_NEXT(a_last_clears, clock, reset,
      rsp_valid && rsp_ready && rsp_data.last, cnt_a_ff == '0 && !drop_ff,
      "state not cleared after last result")
endmodule

### hdl/sso_store.sv
// ----------------------------------------------------------------------------
// sso_store
// Two set memories, one read port each, registered read data.
// ----------------------------------------------------------------------------
module sso_store import sso_pkg::*; #(
   parameter int AW = 5
) (
   input  logic          clock,
   input  store_ctl_type ctl,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [31:0]   rd_a,
   output logic [31:0]   rd_b
);
   logic [31:0] mem_a [2**AW];
   logic [31:0] mem_b [2**AW];
   logic [31:0] wd;

   assign wd = ctl.wr_from_rd ? (ctl.sel_b ? rd_b : rd_a) : wr_data;

   always_ff @(posedge clock) begin
      if (ctl.wr && !ctl.sel_b) mem_a[ctl.wr_addr[AW-1:0]] <= wd;
      if (ctl.wr && ctl.sel_b)  mem_b[ctl.wr_addr[AW-1:0]] <= wd;
      rd_a <= mem_a[rd_addr_a];
      rd_b <= mem_b[rd_addr_b];
   end
endmodule
